### rtl/core/token_lexer_with_symbol_interning_core_defines.svh
// assertion macros used by the checker file
`ifndef TOKEN_LEXER_WITH_SYMBOL_INTERNING_CORE_DEFINES_SVH
`define TOKEN_LEXER_WITH_SYMBOL_INTERNING_CORE_DEFINES_SVH

// property that holds on every clock edge outside reset
`define TLX_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define TLX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/tlx_pkg.sv
// ----------------------------------------------------------------------------
// tlx_pkg
// types, token codes and character classes of the token lexer
// ----------------------------------------------------------------------------
package tlx_pkg;

   localparam int unsigned MAX_SYMBOLS_DEF  = 128;
   localparam int unsigned MAX_NAME_LEN_DEF = 32;

   localparam logic [3:0] KIND_INT    = 4'd0;
   localparam logic [3:0] KIND_VOID   = 4'd1;
   localparam logic [3:0] KIND_RETURN = 4'd2;
   localparam logic [3:0] KIND_IDENT  = 4'd3;
   localparam logic [3:0] KIND_NUMBER = 4'd4;
   localparam logic [3:0] KIND_LPAREN = 4'd5;
   localparam logic [3:0] KIND_RPAREN = 4'd6;
   localparam logic [3:0] KIND_LBRACE = 4'd7;
   localparam logic [3:0] KIND_RBRACE = 4'd8;
   localparam logic [3:0] KIND_SEMI   = 4'd9;
   localparam logic [3:0] KIND_ERROR  = 4'd10;
   localparam logic [3:0] KIND_END    = 4'd11;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [3:0] token_kind;
      logic [6:0] sym_index;
      logic       new_symbol;
      logic       last_of_run;
   } rsp_type;

   // command from the sequencer to the symbol search unit
   typedef struct packed {
      logic start;
   } srch_cmd_type;

   // search outcome
   typedef struct packed {
      logic done;
      logic found;
      logic full;
      logic [9:0] index;
   } srch_res_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

endpackage

### rtl/core/token_lexer_with_symbol_interning_core.sv
// Token lexer: takes one source byte per request and returns zero to two
// tokens. A byte that only extends a word gives no token. Any other byte
// that closes no word goes through accept, decode and emit before its token
// (end of text is emitted at decode). A byte that finishes an identifier or
// number that is no keyword starts a search of the symbol store one entry at
// a time through a single compare unit before the word token appears; the
// byte's own token follows once that one is taken. The block takes no request
// until all tokens of the current one are taken; after an error it takes and
// ignores every byte.
// ----------------------------------------------------------------------------
// token_lexer_with_symbol_interning_core
// lexer sequencer with symbol interning
// ----------------------------------------------------------------------------
module token_lexer_with_symbol_interning_core #(
   parameter int unsigned MAX_SYMBOLS  = tlx_pkg::MAX_SYMBOLS_DEF,
   parameter int unsigned MAX_NAME_LEN = tlx_pkg::MAX_NAME_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tlx_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tlx_pkg::rsp_type rsp_data
);
   localparam int unsigned LW = $clog2(MAX_NAME_LEN + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECIDE, ST_SEARCH, ST_WORD_OUT, ST_SECOND, ST_DEAD
   } state_type;
   typedef enum logic [1:0] {M_IDLE, M_IDENT, M_NUMBER} mode_type;

   state_type state_ff;
   mode_type  mode_ff;
   logic      line_start_ff;
   logic [MAX_NAME_LEN-1:0][7:0] word_ff;
   logic [LW-1:0] wlen_ff;
   tlx_pkg::req_type req_ff;
   tlx_pkg::rsp_type rsp_ff;
   logic rsp_valid_ff;
   tlx_pkg::srch_cmd_type cmd;
   tlx_pkg::srch_res_type res;
   logic [3:0] kw_kind;
   logic       kw_hit;
   logic       quiet;

   tlx_symbol_store #(.MAX_SYMBOLS(MAX_SYMBOLS), .MAX_NAME_LEN(MAX_NAME_LEN)) u_store (
      .clock(clock), .reset(reset), .cmd(cmd), .word(word_ff), .word_len(wlen_ff),
      .res(res));

   // keyword match on the pending word
   always_comb begin
      kw_hit  = 1'b0;
      kw_kind = tlx_pkg::KIND_INT;
      if (mode_ff == M_IDENT) begin
         if (wlen_ff == LW'(3) && MAX_NAME_LEN >= 3 && word_ff[0] == "i" &&
             word_ff[1] == "n" && word_ff[2] == "t") begin
            kw_hit = 1'b1; kw_kind = tlx_pkg::KIND_INT;
         end
         if (wlen_ff == LW'(4) && MAX_NAME_LEN >= 4 && word_ff[0] == "v" &&
             word_ff[1] == "o" && word_ff[2] == "i" && word_ff[3] == "d") begin
            kw_hit = 1'b1; kw_kind = tlx_pkg::KIND_VOID;
         end
         if (MAX_NAME_LEN >= 6 && wlen_ff == LW'(6) && word_ff[0] == "r" &&
             word_ff[1] == "e" && word_ff[2] == "t" && word_ff[3] == "u" &&
             word_ff[4] == "r" && word_ff[5] == "n") begin
            kw_hit = 1'b1; kw_kind = tlx_pkg::KIND_RETURN;
         end
      end
   end

   // byte behind a finished word that gives no token of its own
   assign quiet = !req_ff.end_of_text &&
                  (req_ff.char_code == 8'h0d || req_ff.char_code == 8'h0a ||
                   req_ff.char_code == 8'h00 || req_ff.char_code == 8'h20 ||
                   (line_start_ff && req_ff.char_code >= 8'd9 &&
                    req_ff.char_code <= 8'd13));

   assign req_ready = (state_ff == ST_IDLE && !rsp_valid_ff) || state_ff == ST_DEAD;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign cmd.start = (state_ff == ST_DECIDE) && !kw_hit &&
                      (mode_ff == M_IDENT || mode_ff == M_NUMBER) &&
                      (req_ff.end_of_text ||
                       !(tlx_pkg::is_digit(req_ff.char_code) ||
                         tlx_pkg::is_letter(req_ff.char_code)));

   function automatic tlx_pkg::rsp_type mk(input logic [3:0] k, input logic [6:0] v,
                                           input logic f, input logic l);
      tlx_pkg::rsp_type r;
      r.token_kind = k; r.sym_index = v; r.new_symbol = f; r.last_of_run = l;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      logic [7:0] c;
      logic       pend;
      state_type  nxt;
      logic       vld;
      c = req_ff.char_code;
      pend = 1'b0;
      nxt = state_ff;
      vld = rsp_valid_ff && !rsp_ready;
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= M_IDLE;
         line_start_ff <= 1'b1;
         wlen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid && !rsp_valid_ff) begin
                  req_ff <= req_data;
                  nxt = ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               nxt = ST_IDLE;
               if (req_ff.end_of_text) begin
                  if (mode_ff != M_IDLE) begin
                     pend = 1'b1;
                  end else begin
                     rsp_ff <= mk(tlx_pkg::KIND_END, 7'd0, 1'b0, 1'b1);
                     vld = 1'b1;
                     line_start_ff <= 1'b1;
                     wlen_ff <= '0;
                  end
               end else if (mode_ff != M_IDLE && (tlx_pkg::is_digit(c) ||
                            (mode_ff == M_IDENT && tlx_pkg::is_letter(c)))) begin
                  if (wlen_ff == LW'(MAX_NAME_LEN)) begin
                     rsp_ff <= mk(tlx_pkg::KIND_ERROR, 7'd0, 1'b0, 1'b1);
                     vld = 1'b1;
                     nxt = ST_DEAD;
                  end else begin
                     word_ff[wlen_ff[$clog2(MAX_NAME_LEN)-1:0]] <= c;
                     wlen_ff <= wlen_ff + 1'b1;
                  end
               end else if (mode_ff == M_NUMBER && tlx_pkg::is_letter(c)) begin
                  rsp_ff <= mk(tlx_pkg::KIND_ERROR, 7'd0, 1'b0, 1'b1);
                  vld = 1'b1;
                  nxt = ST_DEAD;
               end else if (mode_ff != M_IDLE) begin
                  pend = 1'b1;
               end else begin
                  nxt = ST_SECOND;
               end
               if (pend) begin
                  if (kw_hit) begin
                     rsp_ff <= mk(kw_kind, 7'd0, 1'b0, quiet);
                     vld = 1'b1;
                     mode_ff <= M_IDLE;
                     wlen_ff <= '0;
                     nxt = ST_WORD_OUT;
                  end else begin
                     nxt = ST_SEARCH;
                  end
               end
            end
            ST_SEARCH: begin
               if (res.done) begin
                  wlen_ff <= '0;
                  if (res.full) begin
                     rsp_ff <= mk(tlx_pkg::KIND_ERROR, 7'd0, 1'b0, 1'b1);
                     vld = 1'b1;
                     nxt = ST_DEAD;
                  end else begin
                     rsp_ff <= mk((mode_ff == M_IDENT) ? tlx_pkg::KIND_IDENT
                                                       : tlx_pkg::KIND_NUMBER,
                                  res.index[6:0], !res.found, quiet);
                     vld = 1'b1;
                     mode_ff <= M_IDLE;
                     nxt = ST_WORD_OUT;
                  end
               end
            end
            ST_WORD_OUT: begin
               // word token waits; then handle the byte as in idle mode
               if (rsp_ready) nxt = ST_SECOND;
            end
            ST_SECOND: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  nxt = ST_IDLE;
                  if (req_ff.end_of_text) begin
                     rsp_ff <= mk(tlx_pkg::KIND_END, 7'd0, 1'b0, 1'b1);
                     vld = 1'b1;
                     line_start_ff <= 1'b1;
                     mode_ff <= M_IDLE;
                  end else if (c == 8'h0d || c == 8'h0a || c == 8'h00) begin
                     line_start_ff <= 1'b1;
                  end else if (c == 8'h20 || (line_start_ff && c >= 8'd9 && c <= 8'd13)) begin
                  end else if (tlx_pkg::is_letter(c) || tlx_pkg::is_digit(c)) begin
                     line_start_ff <= 1'b0;
                     mode_ff <= tlx_pkg::is_digit(c) ? M_NUMBER : M_IDENT;
                     word_ff[0] <= c;
                     wlen_ff <= LW'(1);
                  end else begin
                     line_start_ff <= 1'b0;
                     vld = 1'b1;
                     case (c)
                        8'h28: rsp_ff <= mk(tlx_pkg::KIND_LPAREN, 7'd0, 1'b0, 1'b1);
                        8'h29: rsp_ff <= mk(tlx_pkg::KIND_RPAREN, 7'd0, 1'b0, 1'b1);
                        8'h7b: rsp_ff <= mk(tlx_pkg::KIND_LBRACE, 7'd0, 1'b0, 1'b1);
                        8'h7d: rsp_ff <= mk(tlx_pkg::KIND_RBRACE, 7'd0, 1'b0, 1'b1);
                        8'h3b: rsp_ff <= mk(tlx_pkg::KIND_SEMI, 7'd0, 1'b0, 1'b1);
                        default: begin
                           rsp_ff <= mk(tlx_pkg::KIND_ERROR, 7'd0, 1'b0, 1'b1);
                           nxt = ST_DEAD;
                        end
                     endcase
                  end
               end
            end
            ST_DEAD: ;
            default: nxt = ST_IDLE;
         endcase
         state_ff     <= nxt;
         rsp_valid_ff <= vld;
      end
   end
endmodule

### rtl/core/tlx_symbol_store.sv
// ----------------------------------------------------------------------------
// tlx_symbol_store
// symbol store with a shared compare unit that searches entry by entry
// ----------------------------------------------------------------------------
module tlx_symbol_store #(
   parameter int unsigned MAX_SYMBOLS  = tlx_pkg::MAX_SYMBOLS_DEF,
   parameter int unsigned MAX_NAME_LEN = tlx_pkg::MAX_NAME_LEN_DEF,
   localparam int unsigned SW = $clog2(MAX_SYMBOLS),
   localparam int unsigned LW = $clog2(MAX_NAME_LEN + 1),
   localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tlx_pkg::srch_cmd_type         cmd,
   input  logic [MAX_NAME_LEN-1:0][7:0]  word,
   input  logic [LW-1:0]                 word_len,
   output tlx_pkg::srch_res_type         res
);
   typedef enum logic [1:0] {S_IDLE, S_READ, S_CMP, S_WRITE} state_type;

   logic [MAX_NAME_LEN-1:0][7:0] text_mem [MAX_SYMBOLS];
   logic [LW-1:0]                len_mem  [MAX_SYMBOLS];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [MAX_NAME_LEN-1:0][7:0] rd_text_ff;
   logic [LW-1:0] rd_len_ff;
   tlx_pkg::srch_res_type res_ff, res_in;
   logic match;
   logic [SW-1:0] rd_addr;

   assign rd_addr = idx_ff[SW-1:0];

   // compare of one stored entry with the pending word
   always_comb begin
      match = (rd_len_ff == word_len);
      for (int i = 0; i < MAX_NAME_LEN; i++) begin
         if (i < int'(word_len) && rd_text_ff[i] != word[i]) match = 1'b0;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      res_in   = res_ff;
      res_in.done = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd.start) begin
               idx_in = '0;
               if (count_ff == '0) state_in = S_WRITE;
               else state_in = S_READ;
            end
         end
         S_READ: state_in = S_CMP;
         S_CMP: begin
            if (match) begin
               res_in.done  = 1'b1;
               res_in.found = 1'b1;
               res_in.full  = 1'b0;
               res_in.index = 10'(idx_ff);
               state_in = S_IDLE;
            end else if (idx_ff + 1'b1 == count_ff) begin
               idx_in   = count_ff;
               state_in = S_WRITE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_READ;
            end
         end
         S_WRITE: begin
            res_in.done  = 1'b1;
            res_in.found = 1'b0;
            res_in.index = 10'(count_ff);
            res_in.full  = (count_ff == CW'(MAX_SYMBOLS));
            if (count_ff != CW'(MAX_SYMBOLS)) count_in = count_ff + 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         idx_ff   <= '0;
         res_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         res_ff   <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_text_ff <= text_mem[rd_addr];
      rd_len_ff  <= len_mem[rd_addr];
      if (state_ff == S_WRITE && count_ff != CW'(MAX_SYMBOLS)) begin
         text_mem[count_ff[SW-1:0]] <= word;
         len_mem[count_ff[SW-1:0]]  <= word_len;
      end
   end

   assign res = res_ff;
endmodule

### rtl/core/tlx_checker.sv
// ----------------------------------------------------------------------------
// tlx_checker
// port-level checks of the token lexer
// ----------------------------------------------------------------------------
`include "token_lexer_with_symbol_interning_core_defines.svh"
module tlx_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input tlx_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tlx_pkg::rsp_type rsp_data
);
   logic word_kind;

   assign word_kind = rsp_data.token_kind == tlx_pkg::KIND_IDENT ||
                      rsp_data.token_kind == tlx_pkg::KIND_NUMBER;

   `TLX_ASSERT(a_kind_range, !rsp_valid || rsp_data.token_kind <= tlx_pkg::KIND_END, "bad kind")
   `TLX_ASSERT(a_value_zero, !rsp_valid || word_kind || rsp_data.sym_index == 7'd0, "value on non-word")
   `TLX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped")
   `TLX_ASSERT_NEXT(a_no_double, req_valid && req_ready && !(rsp_valid && rsp_data.token_kind == tlx_pkg::KIND_ERROR), !req_ready || !$past(rsp_valid), "overlap")
endmodule

bind token_lexer_with_symbol_interning_core tlx_checker u_tlx_checker (.*);

### sim/tb_token_lexer_with_symbol_interning_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_token_lexer_with_symbol_interning_core
// self-checking bench for the token lexer with symbol interning
// ----------------------------------------------------------------------------
// Source text goes in one byte per request as random C-like lines of keywords,
// names, numbers and punctuators, with some noise. A lexer model in the
// scoreboard predicts the tokens, and every token that comes out is compared
// with the oldest prediction. Reset is applied once, so error runs come last.
// ----------------------------------------------------------------------------
module tb_token_lexer_with_symbol_interning_core;

   localparam int MAX_SYM = int'(tlx_pkg::MAX_SYMBOLS_DEF);
   localparam int MAX_LEN = int'(tlx_pkg::MAX_NAME_LEN_DEF);
   localparam logic [1:0] MODE_IDLE = 2'd0, MODE_IDENT = 2'd1, MODE_NUMBER = 2'd2,
      MODE_ERROR = 2'd3;

   class lexer_scoreboard;
      logic [1:0]       scan_mode;
      bit               line_start;
      byte              word[$];
      string            symbols[$];
      tlx_pkg::rsp_type pending_tokens[$];
      int               fail_count;

      function void clear();
         scan_mode = MODE_IDLE;
         line_start = 1;
         word.delete();
         symbols.delete();
         pending_tokens.delete();
         fail_count = 0;
      endfunction

      function void push_token(logic [3:0] kind, int value, bit fresh);
         tlx_pkg::rsp_type t;
         t.token_kind = kind;
         t.sym_index = value[6:0];
         t.new_symbol = fresh;
         t.last_of_run = 0;
         pending_tokens.push_back(t);
      endfunction

      function void raise_error();
         push_token(tlx_pkg::KIND_ERROR, 0, 0);
         scan_mode = MODE_ERROR;
      endfunction

      function bit flush_word();
         string s;
         logic [3:0] kind;
         kind = (scan_mode == MODE_IDENT) ? tlx_pkg::KIND_IDENT : tlx_pkg::KIND_NUMBER;
         s = "";
         foreach (word[i]) s = {s, string'(word[i])};
         scan_mode = MODE_IDLE;
         word.delete();
         if (kind == tlx_pkg::KIND_IDENT && s == "int") begin
            push_token(tlx_pkg::KIND_INT, 0, 0); return 1;
         end
         if (kind == tlx_pkg::KIND_IDENT && s == "void") begin
            push_token(tlx_pkg::KIND_VOID, 0, 0); return 1;
         end
         if (kind == tlx_pkg::KIND_IDENT && s == "return") begin
            push_token(tlx_pkg::KIND_RETURN, 0, 0); return 1;
         end
         foreach (symbols[i]) if (symbols[i] == s) begin
            push_token(kind, i, 0); return 1;
         end
         if (symbols.size() >= MAX_SYM) begin
            raise_error(); return 0;
         end
         symbols.push_back(s);
         push_token(kind, symbols.size() - 1, 1);
         return 1;
      endfunction

      function void add_char(byte c);
         if (word.size() >= MAX_LEN) raise_error();
         else word.push_back(c);
      endfunction

      function void note_request(tlx_pkg::req_type r);
         int before_n;
         byte c;
         bit letter, digit;
         before_n = pending_tokens.size();
         c = r.char_code;
         letter = tlx_pkg::is_letter(r.char_code);
         digit = tlx_pkg::is_digit(r.char_code);
         if (scan_mode == MODE_ERROR) return;
         if (r.end_of_text) begin
            if (scan_mode != MODE_IDLE && !flush_word()) begin
            end else begin
               push_token(tlx_pkg::KIND_END, 0, 0);
               scan_mode = MODE_IDLE;
               line_start = 1;
               word.delete();
            end
         end else if ((scan_mode == MODE_IDENT && (letter || digit)) ||
                      (scan_mode == MODE_NUMBER && digit)) begin
            add_char(c);
         end else if (scan_mode == MODE_NUMBER && letter) begin
            word.delete();
            raise_error();
         end else if (scan_mode != MODE_IDLE && !flush_word()) begin
         end else if (r.char_code inside {8'd13, 8'd10, 8'd0}) begin
            line_start = 1;
         end else if (r.char_code == 8'd32) begin
         end else if (line_start && r.char_code >= 8'd9 && r.char_code <= 8'd13) begin
         end else if (letter || digit) begin
            line_start = 0;
            scan_mode = digit ? MODE_NUMBER : MODE_IDENT;
            word.delete();
            add_char(c);
         end else begin
            line_start = 0;
            case (r.char_code)
               8'h28: push_token(tlx_pkg::KIND_LPAREN, 0, 0);
               8'h29: push_token(tlx_pkg::KIND_RPAREN, 0, 0);
               8'h7b: push_token(tlx_pkg::KIND_LBRACE, 0, 0);
               8'h7d: push_token(tlx_pkg::KIND_RBRACE, 0, 0);
               8'h3b: push_token(tlx_pkg::KIND_SEMI, 0, 0);
               default: raise_error();
            endcase
         end
         if (pending_tokens.size() > before_n)
            pending_tokens[pending_tokens.size() - 1].last_of_run = 1;
      endfunction

      function void check_token(tlx_pkg::rsp_type got);
         tlx_pkg::rsp_type exp;
         if (pending_tokens.size() == 0) begin
            $display("%0t: unexpected token exp none act %h", $time, got);
            fail_count++;
            return;
         end
         exp = pending_tokens.pop_front();
         if (got.token_kind !== exp.token_kind) begin
            $display("%0t: token_kind exp %0d act %0d", $time, exp.token_kind, got.token_kind);
            fail_count++;
         end
         if (got.sym_index !== exp.sym_index) begin
            $display("%0t: sym_index exp %0d act %0d", $time, exp.sym_index,
                     got.sym_index);
            fail_count++;
         end
         if (got.new_symbol !== exp.new_symbol) begin
            $display("%0t: new_symbol exp %0b act %0b", $time, exp.new_symbol, got.new_symbol);
            fail_count++;
         end
         if (got.last_of_run !== exp.last_of_run) begin
            $display("%0t: last_of_run exp %0b act %0b", $time, exp.last_of_run,
                     got.last_of_run);
            fail_count++;
         end
      endfunction
   endclass

   logic             clock, reset;
   logic             req_valid, req_ready, rsp_valid, rsp_ready;
   tlx_pkg::req_type req_data;
   tlx_pkg::rsp_type rsp_data;
   lexer_scoreboard  lexer_model;
   bit               hold_off;
   int               sent_count;
   byte              text_queue[$];  // end of text is marked by -1

   token_lexer_with_symbol_interning_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("Regression FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) lexer_model.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) lexer_model.check_token(rsp_data);
   end

   // receiver: random stalls, one long hold-off
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off) begin
            gap = 300;
            hold_off = 0;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
         end
         if (gap > 0) begin
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // valid stays up after a request is taken until the next call changes it
   task automatic send_byte(input int c, input bit burst);
      tlx_pkg::req_type r;
      int gap;
      gap = burst ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      r.char_code = (c < 0) ? 8'($urandom) : 8'(c);
      r.end_of_text = (c < 0);
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_count++;
   endtask

   task automatic queue_text(input string s);
      foreach (s[i]) text_queue.push_back(s[i]);
   endtask

   task automatic queue_random_name(input int n);
      string pool;
      pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      text_queue.push_back(pool[$urandom_range(0, 52)]);
      for (int i = 1; i < n; i++) text_queue.push_back(pool[$urandom_range(0, 62)]);
   endtask

   task automatic queue_random_line();
      string words[] = '{"int", "void", "return", "x", "y1", "main", "_t", "intx", "Ret"};
      string punct = "(){};";
      int n;
      n = $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) text_queue.push_back($urandom_range(0, 1) ? 8'd9 : 8'd32);
      repeat (n) begin
         case ($urandom_range(0, 3))
            0: queue_text(words[$urandom_range(0, 8)]);
            1: queue_random_name($urandom_range(1, 4));
            2: repeat ($urandom_range(1, 3))
               text_queue.push_back(byte'(8'h30 + $urandom_range(0, 9)));
            default: text_queue.push_back(punct[$urandom_range(0, 4)]);
         endcase
         text_queue.push_back($urandom_range(0, 1) ? 8'd32 : punct[$urandom_range(0, 4)]);
      end
      case ($urandom_range(0, 2))
         0: text_queue.push_back(8'd10);
         1: text_queue.push_back(8'd13);
         default: text_queue.push_back(8'd0);
      endcase
   endtask

   task automatic drain_text(input bit burst);
      int c;
      while (text_queue.size() > 0) begin
         c = text_queue.pop_front();
         send_byte(c == -1 ? -1 : (c & 255), burst);
      end
   endtask

   initial begin
      int idle;
      bit held;
      lexer_model = new();
      lexer_model.clear();
      hold_off = 0;
      held = 0;
      sent_count = 0;
      reset = 1;
      req_valid = 0;
      req_data = '0;
      repeat (7) @(negedge clock);
      reset = 0;

      // directed: keywords, numbers, punctuators, line start whitespace
      queue_text("\t int void return abc abc 0 255 (){};\r\n");
      queue_text(" x9 _Z zz");
      text_queue.push_back(-1);
      queue_text("42");
      text_queue.push_back(-1);
      text_queue.push_back(-1);
      drain_text(0);

      // random lines with end markers, one long receiver stall on the way
      while (sent_count < 650) begin
         if (sent_count > 200 && !held) begin
            hold_off = 1;
            held = 1;
         end
         queue_random_line();
         if ($urandom_range(0, 5) == 0) text_queue.push_back(-1);
         drain_text($urandom_range(0, 4) == 0);
      end

      // a name of the longest allowed length
      text_queue.push_back(8'd10);
      repeat (32) text_queue.push_back("q");
      text_queue.push_back(-1);
      drain_text(0);

      // fill the symbol store, then one more new name overflows it
      for (int i = lexer_model.symbols.size(); i <= MAX_SYM; i++) begin
         queue_text($sformatf("s%0d ", i + 1000));
         drain_text(1);
         if (lexer_model.scan_mode == MODE_ERROR) break;
      end
      // forty bytes of random noise and an end marker; after an error token all input is ignored
      repeat (40) send_byte($urandom_range(0, 255), 0);
      send_byte(-1, 0);
      req_valid <= 0;

      idle = 0;
      while (lexer_model.pending_tokens.size() > 0 && idle < 200000) begin
         @(posedge clock);
         idle++;
      end
      repeat (400) @(posedge clock);
      if (lexer_model.fail_count == 0 && lexer_model.pending_tokens.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

### files.f
+incdir+rtl/core
rtl/core/tlx_pkg.sv
rtl/core/tlx_symbol_store.sv
rtl/core/token_lexer_with_symbol_interning_core.sv
rtl/core/tlx_checker.sv
sim/tb_token_lexer_with_symbol_interning_core.sv
